>>> rtl/lgge_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the life grid generation engine.
// Depends on nothing; the interfaces, the row update, the core and the testbench import it.
package lgge_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 16;

    localparam int REQ_W       = 2;
    localparam int COL_W       = 5;
    localparam int ROW_W       = 4;
    localparam int COLS_W      = 6;
    localparam int ROWS_W      = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 5'd16;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2
    } req_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_MOD,
        ST_ADV_L0,
        ST_ADV_L1,
        ST_ADV_L2,
        ST_ADV_RD,
        ST_ADV_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             cell_in;
    } req_item_t;

    typedef struct packed {
        logic cell_out;
        logic step_done;
    } rsp_item_t;

endpackage

>>> rtl/lgge_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response items.
// Depends on lgge_pkg for the item types.
interface lgge_req_if;
    import lgge_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lgge_rsp_if;
    import lgge_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/lgge_row_update.sv
`timescale 1ns / 1ps
// Computes a new row from three old rows by B3/S23; column 0 is kept.
// Depends on lgge_pkg for the default grid width.
module lgge_row_update #(
    parameter int GRID_WIDTH = lgge_pkg::GRID_WIDTH_DEF
) (
    input  logic [GRID_WIDTH-1:0]            prev_row,
    input  logic [GRID_WIDTH-1:0]            cur_row,
    input  logic [GRID_WIDTH-1:0]            next_row,
    input  logic [$clog2(GRID_WIDTH+1)-1:0]  active_cols,
    output logic [GRID_WIDTH-1:0]            new_row
);
    import lgge_pkg::*;

    logic [GRID_WIDTH-1:0] lane_mask;
    logic [GRID_WIDTH+1:0] p_pad;
    logic [GRID_WIDTH+1:0] c_pad;
    logic [GRID_WIDTH+1:0] n_pad;
    logic [3:0]            cnt;

    always_comb
    begin
        for (int x = 0; x < GRID_WIDTH; x++)
        begin
            lane_mask[x] = (x < int'(active_cols));
        end
        p_pad = {1'b0, prev_row & lane_mask, 1'b0};
        c_pad = {1'b0, cur_row & lane_mask, 1'b0};
        n_pad = {1'b0, next_row & lane_mask, 1'b0};
        cnt   = '0;
        new_row = cur_row;
        for (int x = 0; x < GRID_WIDTH; x++)
        begin
            cnt = 4'(p_pad[x]) + 4'(p_pad[x+1]) + 4'(p_pad[x+2])
                + 4'(c_pad[x]) + 4'(c_pad[x+2])
                + 4'(n_pad[x]) + 4'(n_pad[x+1]) + 4'(n_pad[x+2]);
            if (x >= 1 && lane_mask[x])
            begin
                new_row[x] = (cnt == 4'd3) || ((cnt == 4'd2) && c_pad[x+1]);
            end
        end
    end

endmodule

>>> rtl/life_grid_generation_engine_core.sv
`timescale 1ns / 1ps
// Top level of the life grid generation engine: row memory and sequencer.
// Depends on lgge_pkg, lgge_if and lgge_row_update.
//
// Requests arrive as items on the req channel and each one produces exactly
// one item on the rsp channel. A write or read of a cell inside the active area
// goes through the cell read, cell modify and result states before its
// response item is valid. A cell request outside the area, an unused request
// type or an advance on an area narrower or shorter than two skips to result.
// An advance loads rows 0 and 1, then for each row from 1 to the last active
// one reads the row below and writes the whole updated row back through the
// row memory; the grid is kept one row per memory word, row 0 not rewritten.
// The block works on one item at a time; ready is high only while it is idle.
// The response sits in an output register, so a new item is accepted while a
// response still waits; if the receiver stalls, the next response waits in
// the sequencer until the output register frees up.
// Configuration writes take effect immediately and are expected only while
// the block is idle. At reset the grid reads as all dead through per-row
// valid bits, so no clearing pass is needed and the block is ready at once.
module life_grid_generation_engine_core #(
    parameter int GRID_WIDTH  = lgge_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lgge_pkg::GRID_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lgge_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lgge_pkg::CFG_DATA_W-1:0]  cfg_data,
    lgge_req_if.sink                         req,
    lgge_rsp_if.source                       rsp
);
    import lgge_pkg::*;

    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    localparam int COL_AW = $clog2(GRID_WIDTH);
    localparam int ACW    = $clog2(GRID_WIDTH + 1);
    localparam int ARW    = $clog2(GRID_HEIGHT + 1);

    logic [GRID_WIDTH-1:0]  grid_mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0]  rd_data_reg;
    logic                   rd_valid_reg;
    logic [GRID_HEIGHT-1:0] row_valid_reg;

    state_t                 state_reg, state_next;
    logic [COLS_W-1:0]      cols_reg;
    logic [ROWS_W-1:0]      rows_reg;
    req_item_t              item_reg, item_next;
    logic [ROW_AW-1:0]      y_reg, y_next;
    logic [GRID_WIDTH-1:0]  prev_reg, prev_next;
    logic [GRID_WIDTH-1:0]  cur_reg, cur_next;
    logic                   res_cell_reg, res_cell_next;
    logic                   res_done_reg, res_done_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_item_t              out_item_reg, out_item_next;

    logic [ACW-1:0]         active_cols;
    logic [ARW-1:0]         active_rows;
    logic                   in_area_in;
    logic [15:0]            row_wide;
    logic [15:0]            col_wide;
    logic [ROW_AW-1:0]      cell_row_addr;
    logic [COL_AW-1:0]      cell_col_addr;
    logic [ROW_AW-1:0]      y_plus1;
    logic                   next_in_area;
    logic [GRID_WIDTH-1:0]  rd_row;
    logic [GRID_WIDTH-1:0]  next_row;
    logic [GRID_WIDTH-1:0]  new_row;
    logic [ROW_AW-1:0]      rd_addr;
    logic                   wr_en;
    logic [ROW_AW-1:0]      wr_addr;
    logic [GRID_WIDTH-1:0]  wr_data;

    assign active_cols = (16'(cols_reg) > 16'(GRID_WIDTH)) ? ACW'(GRID_WIDTH) : ACW'(cols_reg);
    assign active_rows = (16'(rows_reg) > 16'(GRID_HEIGHT)) ? ARW'(GRID_HEIGHT)
                                                             : ARW'(rows_reg);

    assign in_area_in = (16'(req.item.col) < 16'(active_cols))
                     && (16'(req.item.row) < 16'(active_rows));

    assign row_wide      = 16'(item_reg.row);
    assign col_wide      = 16'(item_reg.col);
    assign cell_row_addr = row_wide[ROW_AW-1:0];
    assign cell_col_addr = col_wide[COL_AW-1:0];

    assign y_plus1      = y_reg + ROW_AW'(1);
    assign next_in_area = (ARW'(y_reg) + ARW'(1)) < active_rows;
    assign rd_row       = rd_valid_reg ? rd_data_reg : '0;
    assign next_row     = next_in_area ? rd_row : '0;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    lgge_row_update #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_row_update (
        .prev_row    (prev_reg),
        .cur_row     (cur_reg),
        .next_row    (next_row),
        .active_cols (active_cols),
        .new_row     (new_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        y_next         = y_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        res_cell_next  = res_cell_reg;
        res_done_next  = res_done_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        rd_addr        = y_reg;
        wr_en          = 1'b0;
        wr_addr        = y_reg;
        wr_data        = new_row;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next     = req.item;
                    res_cell_next = 1'b0;
                    res_done_next = 1'b0;
                    case (req.item.req_type) inside
                        REQ_WRITE, REQ_READ:
                        begin
                            state_next = in_area_in ? ST_CELL_RD : ST_RESULT;
                        end
                        REQ_ADVANCE:
                        begin
                            res_done_next = 1'b1;
                            if (active_cols >= ACW'(2) && active_rows >= ARW'(2))
                            begin
                                state_next = ST_ADV_L0;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_CELL_RD:
            begin
                rd_addr    = cell_row_addr;
                state_next = ST_CELL_MOD;
            end
            ST_CELL_MOD:
            begin
                if (item_reg.req_type == REQ_READ)
                begin
                    res_cell_next = rd_row[cell_col_addr];
                end
                else
                begin
                    wr_en                  = 1'b1;
                    wr_addr                = cell_row_addr;
                    wr_data                = rd_row;
                    wr_data[cell_col_addr] = item_reg.cell_in;
                end
                state_next = ST_RESULT;
            end
            ST_ADV_L0:
            begin
                rd_addr    = '0;
                state_next = ST_ADV_L1;
            end
            ST_ADV_L1:
            begin
                rd_addr    = ROW_AW'(1);
                prev_next  = rd_row;
                state_next = ST_ADV_L2;
            end
            ST_ADV_L2:
            begin
                cur_next   = rd_row;
                y_next     = ROW_AW'(1);
                state_next = ST_ADV_RD;
            end
            ST_ADV_RD:
            begin
                rd_addr    = next_in_area ? y_plus1 : y_reg;
                state_next = ST_ADV_WR;
            end
            ST_ADV_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = y_reg;
                wr_data   = new_row;
                prev_next = cur_reg;
                cur_next  = next_row;
                if (next_in_area)
                begin
                    y_next     = y_plus1;
                    state_next = ST_ADV_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.cell_out  = res_cell_reg;
                    out_item_next.step_done = res_done_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COLS: cols_reg <= cfg_data[COLS_W-1:0];
                    CFG_ROWS: rows_reg <= cfg_data[ROWS_W-1:0];
                    default:  ;
                endcase
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        y_reg        <= y_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        res_cell_reg <= res_cell_next;
        res_done_reg <= res_done_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

endmodule

>>> rtl/lgge_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the life grid generation engine, bound to its top.
// Depends on life_grid_generation_engine_core and its channel interfaces.
module lgge_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_cell,
    input logic out_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_cell) && $stable(out_done))
        else $error("response item changed while stalled");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_cell && out_done))
        else $error("response item flags both a cell value and a finished advance");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request item accepted while the previous one is in work");

    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("response item appeared in the cycle after acceptance");

endmodule

bind life_grid_generation_engine_core lgge_checker u_lgge_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_cell  (rsp.item.cell_out),
    .out_done  (rsp.item.step_done)
);

>>> tb/lgge_grid_checker.sv
`timescale 1ns / 1ps
// Checker for the life grid generation engine: tracks the cell grid and the area registers,
// predicts each response item and compares it with what the block returns.
// Depends on lgge_pkg and the channel interfaces in lgge_if.
module lgge_grid_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lgge_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lgge_pkg::CFG_DATA_W-1:0]  cfg_data,
    lgge_req_if                              req,
    lgge_rsp_if                              rsp,
    output int                               fail_count,
    output int                               outstanding
);
    import lgge_pkg::*;

    localparam int W = GRID_WIDTH_DEF;
    localparam int H = GRID_HEIGHT_DEF;

    bit                live_cells [H][W];
    bit                snap_cells [H][W];
    logic [COLS_W-1:0] cols_set;
    logic [ROWS_W-1:0] rows_set;
    rsp_item_t         pending_rsp [$];

    function automatic int area_cols();
        return (int'(cols_set) > W) ? W : int'(cols_set);
    endfunction

    function automatic int area_rows();
        return (int'(rows_set) > H) ? H : int'(rows_set);
    endfunction

    function automatic bit in_area(int x, int y);
        return x >= 0 && y >= 0 && x < area_cols() && y < area_rows();
    endfunction

    function automatic int snap_alive(int x, int y);
        if (!in_area(x, y))
            return 0;
        return int'(snap_cells[y][x]);
    endfunction

    function automatic void step_generation();
        int w;
        int h;
        int n;
        w = area_cols();
        h = area_rows();
        snap_cells = live_cells;
        for (int x = 1; x < w; x++)
        begin
            for (int y = 1; y < h; y++)
            begin
                n = snap_alive(x, y + 1) + snap_alive(x, y - 1)
                    + snap_alive(x + 1, y) + snap_alive(x + 1, y + 1)
                    + snap_alive(x + 1, y - 1) + snap_alive(x - 1, y)
                    + snap_alive(x - 1, y + 1) + snap_alive(x - 1, y - 1);
                if (n == 3)
                    live_cells[y][x] = 1'b1;
                else if (n != 2)
                    live_cells[y][x] = 1'b0;
            end
        end
    endfunction

    function automatic rsp_item_t apply_request(req_item_t it);
        rsp_item_t r;
        int        x;
        int        y;
        r = '0;
        x = int'(it.col);
        y = int'(it.row);
        case (it.req_type)
            REQ_WRITE:
            begin
                if (in_area(x, y))
                    live_cells[y][x] = it.cell_in;
            end
            REQ_READ:
            begin
                if (in_area(x, y))
                    r.cell_out = live_cells[y][x];
            end
            REQ_ADVANCE:
            begin
                step_generation();
                r.step_done = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        if (!rst_n)
        begin
            foreach (live_cells[y, x])
            begin
                live_cells[y][x] = 1'b0;
                snap_cells[y][x] = 1'b0;
            end
            cols_set = COLS_RESET;
            rows_set = ROWS_RESET;
            pending_rsp.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected response item: cell_out %0b step_done %0b",
                           rsp.item.cell_out, rsp.item.step_done);
                    fail_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.item.cell_out !== want.cell_out)
                    begin
                        $error("cell_out mismatch: expected %0b, actual %0b",
                               want.cell_out, rsp.item.cell_out);
                        fail_count++;
                    end
                    if (rsp.item.step_done !== want.step_done)
                    begin
                        $error("step_done mismatch: expected %0b, actual %0b",
                               want.step_done, rsp.item.step_done);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                pending_rsp.push_back(apply_request(req.item));
            if (cfg_we)
            begin
                if (cfg_index == CFG_COLS)
                    cols_set = cfg_data[COLS_W-1:0];
                else
                    rows_set = cfg_data[ROWS_W-1:0];
            end
            outstanding = pending_rsp.size();
        end
    end

endmodule

>>> tb/tb_life_grid_generation_engine_core.sv
`timescale 1ns / 1ps
// Testbench top for the life grid generation engine: drives cell, advance and unused requests and area settings
// under varied handshake pacing and reports the verdict of lgge_grid_checker.
// Depends on lgge_pkg, lgge_if, the block and tb/lgge_grid_checker.sv.
module tb_life_grid_generation_engine_core;
    import lgge_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               PHASES      = 8;
    localparam int               PHASE_ITEMS = 92;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     outstanding;
    int                     send_idle_pct;
    int                     stall_pct;
    int                     cycles;
    int                     n_sent;
    int                     n_adv;
    int                     n_read;

    lgge_req_if req_ch ();
    lgge_rsp_if rsp_ch ();

    life_grid_generation_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    lgge_grid_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_req(input logic [REQ_W-1:0] kind, input int c, input int r,
                            input bit v);
        req_item_t it;
        it.req_type = kind;
        it.col      = c[COL_W-1:0];
        it.row      = r[ROW_W-1:0];
        it.cell_in  = v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item  <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        n_sent++;
        if (kind == REQ_ADVANCE)
            n_adv++;
        if (kind == REQ_READ)
            n_read++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int               cols_tab [PHASES];
        int               rows_tab [PHASES];
        int               w;
        int               h;
        int               pick;
        int               c;
        int               r;
        logic [REQ_W-1:0] kind;
        cols_tab      = '{32, 2, 63, 0, 1, 17, 2, 32};
        rows_tab      = '{16, 2, 31, 0, 1, 9, 16, 3};
        n_sent        = 0;
        n_adv         = 0;
        n_read        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_COLS;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.item   = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A blinker at column 5, rows 4 to 6, a corner that grows into a block and a lone origin cell.
        send_req(REQ_WRITE, 0, 0, 1'b1);
        send_req(REQ_WRITE, 31, 15, 1'b1);
        send_req(REQ_READ, 0, 0, 1'b0);
        send_req(REQ_READ, 31, 15, 1'b0);
        send_req(REQ_UNUSED, 31, 15, 1'b1);
        send_req(REQ_WRITE, 5, 4, 1'b1);
        send_req(REQ_WRITE, 5, 5, 1'b1);
        send_req(REQ_WRITE, 5, 6, 1'b1);
        send_req(REQ_WRITE, 30, 14, 1'b1);
        send_req(REQ_WRITE, 30, 15, 1'b1);
        send_req(REQ_ADVANCE, 0, 0, 1'b0);
        send_req(REQ_READ, 4, 5, 1'b0);
        send_req(REQ_READ, 5, 5, 1'b0);
        send_req(REQ_READ, 6, 5, 1'b0);
        send_req(REQ_READ, 31, 14, 1'b0);
        send_req(REQ_READ, 0, 0, 1'b0);
        send_req(REQ_ADVANCE, 31, 15, 1'b1);
        send_req(REQ_READ, 5, 4, 1'b0);
        send_req(REQ_WRITE, 0, 0, 1'b0);
        send_req(REQ_READ, 0, 0, 1'b0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_COLS, cols_tab[p]);
            write_reg(CFG_ROWS, rows_tab[p]);
            w = (cols_tab[p] > GRID_WIDTH_DEF) ? GRID_WIDTH_DEF : cols_tab[p];
            h = (rows_tab[p] > GRID_HEIGHT_DEF) ? GRID_HEIGHT_DEF : rows_tab[p];
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 51;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    kind = REQ_WRITE;
                else if (pick < 82)
                    kind = REQ_READ;
                else if (pick < 94)
                    kind = REQ_ADVANCE;
                else
                    kind = REQ_UNUSED;
                if (w > 0 && h > 0 && $urandom_range(99) < 85)
                begin
                    c = $urandom_range(w - 1);
                    r = $urandom_range(h - 1);
                end
                else
                begin
                    c = $urandom_range(31);
                    r = $urandom_range(15);
                end
                send_req(kind, c, r, 1'($urandom_range(1)));
            end
            drain();
        end

        stall_pct = 0;
        $display("Sent %0d requests (%0d advances, %0d reads) over %0d area settings,",
                 n_sent, n_adv, n_read, PHASES + 1);
        $display("including empty, minimal and oversized areas, under four pacing modes.");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
